FILE: sv/mqlm_pkg.sv
package mqlm_pkg;

  localparam int NUM_QUEUES = 16;
  localparam int POOL_DEPTH = 256;
  localparam int DATA_W     = 32;
  localparam int QW         = $clog2(NUM_QUEUES);
  localparam int PW         = $clog2(POOL_DEPTH);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef logic [QW-1:0] qidx_t;
  typedef logic [PW-1:0] ptr_t;
  typedef logic [PW:0]   cnt_t;

  typedef enum logic {
    OP_ENQ,
    OP_DEQ
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_LOOKUP,
    S_UPDATE
  } state_e;

  typedef struct packed {
    op_e                      op;
    qidx_t                    q;
    logic signed [DATA_W-1:0] word;
  } item_t;

  localparam logic [DATA_W-1:0] NEG_ONE = '1;

endpackage

FILE: sv/multi_queue_linked_manager_top.sv
// An accepted word passes a 2-entry queue that decouples input, then the lookup/update
// sequence of the back end around the registered-read link and data memories; the result
// is registered at update, held by output stall; the next lookup waits for that update.
// Reset: all queues empty, free list full; never-allocated entries are tracked by a
// fill count, so no clearing pass runs and words are accepted right after reset.
module multi_queue_linked_manager_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [3:0]         queue_index_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] read_value_o,
  output logic [1:0]         status_o
);

  logic            item_valid;
  logic            item_pop;
  mqlm_pkg::item_t item;

  mqlm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .queue_index_i (queue_index_i),
    .value_i       (value_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  mqlm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .status_o     (status_o)
  );

endmodule

FILE: sv/mqlm_ram.sv
module mqlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/mqlm_front.sv
module mqlm_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic [3:0]            queue_index_i,
  input  logic signed [31:0]    value_i,
  output logic                  item_valid_o,
  output mqlm_pkg::item_t       item_o,
  input  logic                  item_pop_i
);

  mqlm_pkg::item_t                    buf_q [mqlm_pkg::FIFO_DEPTH];
  logic [mqlm_pkg::FIFO_AW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [mqlm_pkg::FIFO_CW-1:0]       cnt_q, cnt_d;
  mqlm_pkg::item_t                    cls;
  logic                               push;

  // classify the incoming word
  always_comb begin
    cls.op   = action_i ? mqlm_pkg::OP_DEQ : mqlm_pkg::OP_ENQ;
    cls.q    = mqlm_pkg::qidx_t'(queue_index_i);
    cls.word = value_i;
  end

  assign in_stall_o   = (cnt_q == mqlm_pkg::FIFO_CW'(mqlm_pkg::FIFO_DEPTH));
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = buf_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = wr_q + 1'b1;
    end
    if (item_pop_i) begin
      rd_d = rd_q + 1'b1;
    end
    if (push && !item_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && item_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= cls;
    end
  end

endmodule

FILE: sv/mqlm_back.sv
module mqlm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  mqlm_pkg::item_t       item_i,
  output logic                  item_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [31:0]    read_value_o,
  output logic [1:0]            status_o
);

  mqlm_pkg::state_e   state_q, state_d;
  logic               pop, commit, out_free;

  mqlm_pkg::ptr_t     head_q [mqlm_pkg::NUM_QUEUES];
  mqlm_pkg::ptr_t     tail_q [mqlm_pkg::NUM_QUEUES];
  logic [mqlm_pkg::NUM_QUEUES-1:0] nonempty_q;
  mqlm_pkg::ptr_t     free_head_q;
  mqlm_pkg::cnt_t     free_count_q;
  mqlm_pkg::cnt_t     fill_q;  // entries at or above this were never allocated

  mqlm_pkg::item_t    cur_q;
  mqlm_pkg::ptr_t     e_q;
  logic               ok_q, fresh_q, last_q;
  mqlm_pkg::status_e  res_q;

  logic               out_valid_q;
  logic [mqlm_pkg::DATA_W-1:0] rv_q;
  mqlm_pkg::status_e  st_q;

  logic               next_we;
  mqlm_pkg::ptr_t     next_waddr, next_wdata, next_raddr, next_rdata;
  logic               data_we;
  logic [mqlm_pkg::DATA_W-1:0] data_rdata;

  logic               lk_enq, lk_ok;
  mqlm_pkg::ptr_t     lk_e;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mqlm_pkg::S_LOOKUP: begin
        if (item_valid_i) begin
          state_d = mqlm_pkg::S_UPDATE;
        end
      end
      mqlm_pkg::S_UPDATE: begin
        if (out_free) begin
          state_d = mqlm_pkg::S_LOOKUP;
        end
      end
      default: state_d = mqlm_pkg::S_LOOKUP;
    endcase
  end

  // FSM outputs
  always_comb begin
    pop    = 1'b0;
    commit = 1'b0;
    case (state_q)
      mqlm_pkg::S_LOOKUP: pop    = item_valid_i;
      mqlm_pkg::S_UPDATE: commit = out_free;
      default: ;
    endcase
  end

  assign item_pop_o = pop;

  // lookup decode
  always_comb begin
    lk_enq = (item_i.op == mqlm_pkg::OP_ENQ);
    if (lk_enq) begin
      lk_ok = (free_count_q != '0);
      lk_e  = free_head_q;
    end else begin
      lk_ok = nonempty_q[item_i.q];
      lk_e  = head_q[item_i.q];
    end
  end

  assign next_raddr = lk_e;

  // one write port on the link store: tail link at lookup, entry link at update
  always_comb begin
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    if (pop && lk_enq && lk_ok && nonempty_q[item_i.q]) begin
      next_we    = 1'b1;
      next_waddr = tail_q[item_i.q];
      next_wdata = free_head_q;
    end else if (commit && ok_q) begin
      next_we    = 1'b1;
      next_waddr = e_q;
      next_wdata = (cur_q.op == mqlm_pkg::OP_ENQ) ? '0 : free_head_q;
    end
  end

  assign data_we = commit && ok_q && (cur_q.op == mqlm_pkg::OP_ENQ);

  mqlm_ram #(
    .WIDTH (mqlm_pkg::PW),
    .DEPTH (mqlm_pkg::POOL_DEPTH)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (pop),
    .raddr_i (next_raddr),
    .rdata_o (next_rdata)
  );

  mqlm_ram #(
    .WIDTH (mqlm_pkg::DATA_W),
    .DEPTH (mqlm_pkg::POOL_DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (e_q),
    .wdata_i (cur_q.word),
    .re_i    (pop),
    .raddr_i (lk_e),
    .rdata_o (data_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mqlm_pkg::S_LOOKUP;
      nonempty_q   <= '0;
      free_head_q  <= '0;
      free_count_q <= mqlm_pkg::cnt_t'(mqlm_pkg::POOL_DEPTH);
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (commit && ok_q) begin
        if (cur_q.op == mqlm_pkg::OP_ENQ) begin
          // untouched entries chain to their successor
          free_head_q  <= fresh_q ? mqlm_pkg::ptr_t'(e_q + 1'b1) : next_rdata;
          free_count_q <= free_count_q - 1'b1;
          if (fresh_q) begin
            fill_q <= fill_q + 1'b1;
          end
          nonempty_q[cur_q.q] <= 1'b1;
        end else begin
          free_head_q <= e_q;
          if (free_count_q < mqlm_pkg::cnt_t'(mqlm_pkg::POOL_DEPTH)) begin
            free_count_q <= free_count_q + 1'b1;
          end
          if (last_q) begin
            nonempty_q[cur_q.q] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q   <= item_i;
      e_q     <= lk_e;
      ok_q    <= lk_ok;
      fresh_q <= ({1'b0, free_head_q} >= fill_q);
      last_q  <= (head_q[item_i.q] == tail_q[item_i.q]);
      if (lk_ok) begin
        res_q <= mqlm_pkg::ST_OK;
      end else if (lk_enq) begin
        res_q <= mqlm_pkg::ST_FULL;
      end else begin
        res_q <= mqlm_pkg::ST_EMPTY;
      end
    end
    if (commit) begin
      st_q <= res_q;
      rv_q <= (ok_q && cur_q.op == mqlm_pkg::OP_DEQ) ? data_rdata : mqlm_pkg::NEG_ONE;
      if (ok_q) begin
        if (cur_q.op == mqlm_pkg::OP_ENQ) begin
          if (!nonempty_q[cur_q.q]) begin
            head_q[cur_q.q] <= e_q;
          end
          tail_q[cur_q.q] <= e_q;
        end else if (!last_q) begin
          head_q[cur_q.q] <= next_rdata;
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rv_q;
  assign status_o     = st_q;

  a_pop_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> state_q == mqlm_pkg::S_UPDATE)
    else $error("lookup did not move to update");

  a_commit_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed item left no result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_q <= mqlm_pkg::cnt_t'(mqlm_pkg::POOL_DEPTH)
      && fill_q <= mqlm_pkg::cnt_t'(mqlm_pkg::POOL_DEPTH))
    else $error("free count or fill count out of range");

  a_enq_marks_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && ok_q && cur_q.op == mqlm_pkg::OP_ENQ) |=> nonempty_q[$past(cur_q.q)])
    else $error("enqueue left queue marked empty");

endmodule
